FILE: rtl/core/ascii_range_frame_parser_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rangefinder frame parser
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASCII_RANGE_FRAME_PARSER_MACROS_SVH
`define ASCII_RANGE_FRAME_PARSER_MACROS_SVH

`ifndef SYNTHESIS
// A property that must hold at every clock edge out of reset.
`define ARFP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// An implication checked at the same edge.
`define ARFP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// An implication whose consequent is checked at the next edge.
`define ARFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ARFP_ASSERT(label, prop, msg)
`define ARFP_ASSERT_IMP(label, ante, cons, msg)
`define ARFP_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: rtl/core/arfp_pkg.sv
// ----------------------------------------------------------------------------
// Rangefinder frame parser package
// Byte codes, parser phases, event codes, register indexes and defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package arfp_pkg;

    // Default digit limits of the two numeric fields.
    localparam int DIST_DIGITS_DEF = 5;
    localparam int CONF_DIGITS_DEF = 2;

    // Field widths.
    localparam int DIST_W = 16;
    localparam int CONF_W = 7;
    localparam int CNT_W  = 32;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;

    typedef logic [1:0] event_t;
    typedef logic [1:0] phase_t;

    // Bytes of the frame syntax.
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_COMMA = 8'h2C;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;
    localparam logic [7:0] BYTE_NINE  = 8'h39;

    // Parser phases.
    localparam phase_t PH_HEAD = 2'd0;
    localparam phase_t PH_DIST = 2'd1;
    localparam phase_t PH_SEP  = 2'd2;
    localparam phase_t PH_CONF = 2'd3;

    // Result events.
    localparam event_t EV_NONE = 2'd0;
    localparam event_t EV_GOOD = 2'd1;
    localparam event_t EV_BAD  = 2'd2;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_MIN_DIST  = 2'd0;
    localparam logic [IDX_W-1:0] REG_MAX_DIST  = 2'd1;
    localparam logic [IDX_W-1:0] REG_MAX_CONF  = 2'd2;
    localparam logic [IDX_W-1:0] REG_JUMP_THR  = 2'd3;

    // Register reset values.
    localparam logic [DIST_W-1:0] MIN_DIST_RST = 16'd0;
    localparam logic [DIST_W-1:0] MAX_DIST_RST = 16'hFFFF;
    localparam logic [CONF_W-1:0] MAX_CONF_RST = 7'd99;
    localparam logic [DIST_W-1:0] JUMP_THR_RST = 16'd200;

endpackage

FILE: rtl/core/ascii_range_frame_parser.sv
// ----------------------------------------------------------------------------
// ASCII rangefinder frame parser
// Parses " <distance>, <confidence>\n" frames one byte at a time.
// ----------------------------------------------------------------------------
// Usage:
// Bytes from the sensor link enter on the input channel (in_valid, in_stall,
// rx_data). Every accepted byte, a carriage return included, yields exactly
// one result request on the output channel: the event code, the held
// distance and confidence, the per-frame jump flags and both frame counts.
// A byte is first captured in an input register; the parse, the limit check
// and the jump compare are done in one pass from that register into the
// result register, which drives out_valid. One byte is accepted every cycle
// while the receiver keeps out_stall low. When the receiver stalls, the
// result register holds its request and the input register takes one more
// byte; then in_stall rises until the result is taken. Reset clears the
// parser to the header wait, zeroes the held values and counters, loads the
// register defaults and drops both valids. Configuration writes on cfg_wen
// take effect at the next edge; the user must make them only while the
// block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ascii_range_frame_parser_macros.svh"

module ascii_range_frame_parser #(
    parameter int DIST_DIGITS = arfp_pkg::DIST_DIGITS_DEF,
    parameter int CONF_DIGITS = arfp_pkg::CONF_DIGITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write port.
    input  logic                          cfg_wen,
    input  logic [arfp_pkg::IDX_W-1:0]    cfg_index,
    input  logic [arfp_pkg::CFG_W-1:0]    cfg_data,
    // Byte input channel.
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    rx_data,
    // Result channel.
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    event_res,
    output logic [arfp_pkg::DIST_W-1:0]   distance,
    output logic [arfp_pkg::CONF_W-1:0]   confidence,
    output logic                          jump_up,
    output logic                          jump_down,
    output logic [arfp_pkg::CNT_W-1:0]    good_frames,
    output logic [arfp_pkg::CNT_W-1:0]    bad_frames
);

    import arfp_pkg::*;

    localparam int DCNT_W = $clog2(DIST_DIGITS + 1);
    localparam int CCNT_W = $clog2(CONF_DIGITS + 1);

    // Configuration registers.
    logic [DIST_W-1:0] min_dist_reg;
    logic [DIST_W-1:0] max_dist_reg;
    logic [CONF_W-1:0] max_conf_reg;
    logic [DIST_W-1:0] jump_thr_reg;

    // Input register.
    logic              s1_valid_reg;
    logic [7:0]        s1_byte_reg;

    // Parser state.
    phase_t            phase_reg,       phase_next;
    logic [DIST_W-1:0] dist_accum_reg,  dist_accum_next;
    logic [DCNT_W-1:0] dist_digits_reg, dist_digits_next;
    logic [CONF_W-1:0] conf_accum_reg,  conf_accum_next;
    logic [CCNT_W-1:0] conf_digits_reg, conf_digits_next;
    logic [DIST_W-1:0] prior_dist_reg,  prior_dist_next;
    logic              prior_valid_reg, prior_valid_next;
    logic [DIST_W-1:0] held_dist_reg,   held_dist_next;
    logic [CONF_W-1:0] held_conf_reg,   held_conf_next;
    logic [CNT_W-1:0]  good_count_reg,  good_count_next;
    logic [CNT_W-1:0]  bad_count_reg,   bad_count_next;

    // Result register.
    logic              out_valid_reg;
    event_t            event_reg,       event_next;
    logic              jump_up_reg,     jump_up_next;
    logic              jump_down_reg,   jump_down_next;

    // Handshake control.
    logic              out_ready;
    logic              s1_adv;
    logic              in_accept;

    // Datapath helpers.
    logic              is_digit;
    logic [3:0]        digit_val;
    logic [DIST_W+3:0] dist_prod;
    logic [CONF_W+3:0] conf_prod;
    logic              frame_ok;

    // The result register frees when empty or when its request is taken.
    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_accept = in_valid && !in_stall;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dist_reg <= MIN_DIST_RST;
            max_dist_reg <= MAX_DIST_RST;
            max_conf_reg <= MAX_CONF_RST;
            jump_thr_reg <= JUMP_THR_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_MIN_DIST: min_dist_reg <= cfg_data;
                REG_MAX_DIST: max_dist_reg <= cfg_data;
                REG_MAX_CONF: max_conf_reg <= cfg_data[CONF_W-1:0];
                REG_JUMP_THR: jump_thr_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Input register: valid is control, the byte is payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= rx_data;
        end
    end

    // Digit decode and the times-ten accumulators, which wrap at field width.
    always_comb
    begin
        is_digit  = s1_byte_reg inside {[BYTE_ZERO:BYTE_NINE]};
        digit_val = s1_byte_reg[3:0];
        dist_prod = (DIST_W+4)'(dist_accum_reg) * (DIST_W+4)'(10)
                    + (DIST_W+4)'(digit_val);
        conf_prod = (CONF_W+4)'(conf_accum_reg) * (CONF_W+4)'(10)
                    + (CONF_W+4)'(digit_val);
        frame_ok  = (dist_accum_reg >= min_dist_reg) && (dist_accum_reg <= max_dist_reg)
                    && (conf_accum_reg != '0) && (conf_accum_reg <= max_conf_reg);
    end

    // Parser next state for the byte in the input register.
    always_comb
    begin
        phase_next       = phase_reg;
        dist_accum_next  = dist_accum_reg;
        dist_digits_next = dist_digits_reg;
        conf_accum_next  = conf_accum_reg;
        conf_digits_next = conf_digits_reg;
        prior_dist_next  = prior_dist_reg;
        prior_valid_next = prior_valid_reg;
        held_dist_next   = held_dist_reg;
        held_conf_next   = held_conf_reg;
        event_next       = EV_NONE;
        jump_up_next     = 1'b0;
        jump_down_next   = 1'b0;

        if (s1_byte_reg != BYTE_CR)
        begin
            case (phase_reg)
                PH_HEAD:
                begin
                    if (s1_byte_reg == BYTE_SPACE)
                    begin
                        phase_next       = PH_DIST;
                        dist_accum_next  = '0;
                        dist_digits_next = '0;
                    end
                end
                PH_DIST:
                begin
                    if (s1_byte_reg == BYTE_COMMA && dist_digits_reg != '0)
                    begin
                        phase_next = PH_SEP;
                    end
                    else if (is_digit && dist_digits_reg < DCNT_W'(DIST_DIGITS))
                    begin
                        dist_accum_next  = dist_prod[DIST_W-1:0];
                        dist_digits_next = dist_digits_reg + DCNT_W'(1);
                    end
                    else
                    begin
                        phase_next = PH_HEAD;
                        event_next = EV_BAD;
                    end
                end
                PH_SEP:
                begin
                    if (s1_byte_reg == BYTE_SPACE)
                    begin
                        phase_next       = PH_CONF;
                        conf_accum_next  = '0;
                        conf_digits_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_HEAD;
                        event_next = EV_BAD;
                    end
                end
                PH_CONF:
                begin
                    if (s1_byte_reg == BYTE_LF && conf_digits_reg != '0)
                    begin
                        phase_next = PH_HEAD;
                        if (frame_ok)
                        begin
                            held_dist_next = dist_accum_reg;
                            held_conf_next = conf_accum_reg;
                            // Jumps are measured against the previous good frame only.
                            if (prior_valid_reg)
                            begin
                                if (dist_accum_reg > prior_dist_reg
                                    && (dist_accum_reg - prior_dist_reg) >= jump_thr_reg)
                                begin
                                    jump_up_next = 1'b1;
                                end
                                else if (prior_dist_reg > dist_accum_reg
                                    && (prior_dist_reg - dist_accum_reg) >= jump_thr_reg)
                                begin
                                    jump_down_next = 1'b1;
                                end
                            end
                            prior_dist_next  = dist_accum_reg;
                            prior_valid_next = 1'b1;
                            event_next       = EV_GOOD;
                        end
                        else
                        begin
                            event_next = EV_BAD;
                        end
                    end
                    else if (is_digit && conf_digits_reg < CCNT_W'(CONF_DIGITS))
                    begin
                        conf_accum_next  = conf_prod[CONF_W-1:0];
                        conf_digits_next = conf_digits_reg + CCNT_W'(1);
                    end
                    else
                    begin
                        phase_next = PH_HEAD;
                        event_next = EV_BAD;
                    end
                end
                default:
                begin
                    phase_next = PH_HEAD;
                end
            endcase
        end
    end

    // Frame counters follow the event of this byte.
    always_comb
    begin
        good_count_next = good_count_reg;
        bad_count_next  = bad_count_reg;
        if (event_next == EV_GOOD)
        begin
            good_count_next = good_count_reg + CNT_W'(1);
        end
        else if (event_next == EV_BAD)
        begin
            bad_count_next = bad_count_reg + CNT_W'(1);
        end
    end

    // Parser state and the result register advance together.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEAD;
            dist_accum_reg  <= '0;
            dist_digits_reg <= '0;
            conf_accum_reg  <= '0;
            conf_digits_reg <= '0;
            prior_dist_reg  <= '0;
            prior_valid_reg <= 1'b0;
            held_dist_reg   <= '0;
            held_conf_reg   <= '0;
            good_count_reg  <= '0;
            bad_count_reg   <= '0;
            event_reg       <= EV_NONE;
            jump_up_reg     <= 1'b0;
            jump_down_reg   <= 1'b0;
        end
        else if (s1_adv)
        begin
            phase_reg       <= phase_next;
            dist_accum_reg  <= dist_accum_next;
            dist_digits_reg <= dist_digits_next;
            conf_accum_reg  <= conf_accum_next;
            conf_digits_reg <= conf_digits_next;
            prior_dist_reg  <= prior_dist_next;
            prior_valid_reg <= prior_valid_next;
            held_dist_reg   <= held_dist_next;
            held_conf_reg   <= held_conf_next;
            good_count_reg  <= good_count_next;
            bad_count_reg   <= bad_count_next;
            event_reg       <= event_next;
            jump_up_reg     <= jump_up_next;
            jump_down_reg   <= jump_down_next;
        end
    end

    // Result valid: set on load, cleared when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // The held values and counters change only on a result load.
    assign out_valid   = out_valid_reg;
    assign event_res   = event_reg;
    assign distance    = held_dist_reg;
    assign confidence  = held_conf_reg;
    assign jump_up     = jump_up_reg;
    assign jump_down   = jump_down_reg;
    assign good_frames = good_count_reg;
    assign bad_frames  = bad_count_reg;

    // Checks.
    `ARFP_ASSERT_IMP(a_jump_on_good, jump_up_reg || jump_down_reg, event_reg == EV_GOOD, "jump flag without a good frame")
    `ARFP_ASSERT(a_jump_exclusive, !(jump_up_reg && jump_down_reg), "both jump flags set")
    `ARFP_ASSERT(a_dist_digits, dist_digits_reg <= DCNT_W'(DIST_DIGITS), "distance digit count overrun")
    `ARFP_ASSERT_IMP(a_sep_has_digit, phase_reg == PH_SEP, dist_digits_reg != '0, "separator phase without distance digit")
    `ARFP_ASSERT_NEXT(a_stall_holds, out_valid_reg && out_stall, out_valid_reg && $stable(good_count_reg) && $stable(bad_count_reg), "stalled result changed")

endmodule
